// ===== design/vwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume weighted centroid package
// Shared widths, register codes, divider states and the structs that pass
// between the front end, the accumulator, the divider and the top level.
// ----------------------------------------------------------------------------
package vwc_pkg;

   localparam int VALUE_W    = 8;
   localparam int CFG_W      = 11;
   localparam int MOMENT_W   = 48;
   localparam int MASS_W     = 38;
   localparam int COORD_W    = 18;
   localparam int FRAC_W     = 8;
   localparam int NUM_W      = MOMENT_W + FRAC_W;
   localparam int STEP_W     = $clog2(NUM_W);
   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(1024);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_VOL_WIDTH  = 2'd0;
   localparam logic [1:0] REG_VOL_HEIGHT = 2'd1;
   localparam logic [1:0] REG_VOL_DEPTH  = 2'd2;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef struct packed {
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] height;
      logic [CFG_W-1:0] depth;
   } dims_type;

   typedef struct packed {
      logic interior;
      logic last;
   } tag_type;

   typedef struct packed {
      logic [MOMENT_W-1:0] moment_x;
      logic [MOMENT_W-1:0] moment_y;
      logic [MOMENT_W-1:0] moment_z;
      logic [MASS_W-1:0]   mass;
   } sums_type;

endpackage

// ===== design/vwc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel request channel
// Valid/ready channel that carries one voxel intensity per beat.
// ----------------------------------------------------------------------------
interface vwc_req_if;
   logic                        valid;
   logic                        ready;
   logic [vwc_pkg::VALUE_W-1:0] voxel_value;

   modport source (output valid, output voxel_value, input ready);
   modport sink (input valid, input voxel_value, output ready);
endinterface

// ===== design/vwc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centroid response channel
// Valid/ready channel that carries one centroid result per beat.
// ----------------------------------------------------------------------------
interface vwc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vwc_pkg::COORD_W-1:0] centroid_x;
   logic [vwc_pkg::COORD_W-1:0] centroid_y;
   logic [vwc_pkg::COORD_W-1:0] centroid_z;
   logic                        empty_volume;

   modport source (output valid, output centroid_x, output centroid_y,
                   output centroid_z, output empty_volume, input ready);
   modport sink (input valid, input centroid_x, input centroid_y,
                 input centroid_z, input empty_volume, output ready);
endinterface

// ===== design/volume_weighted_centroid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume weighted centroid
// Streams the voxels of a volume and returns the intensity weighted centroid
// of its interior, with 8 fraction bits, once per volume.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   --------  ---------  ---------------------------------------------------
//   req_chan  in         voxel_value, one voxel in raster order, x fastest
//   rsp_chan  out        centroid_x/y/z and empty_volume, one per volume
//   csr_*     in/out     APB registers vol_width, vol_height, vol_depth
//
// The block takes one voxel beat per cycle while the voxel queue has room.
// The last voxel of a volume hands its sums to a shared restoring divider
// that works through the x, y and z axes in turn.
// Voxels of the next volume keep flowing while the divider works; only the
// next volume's last voxel waits if the previous result is still pending.
// Reset is synchronous: it restores all three dimensions to 1024 and clears
// the positions, the sums, the queue and the divider; no clearing pass.
// ----------------------------------------------------------------------------
module volume_weighted_centroid #(
   parameter int MAX_DIM = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   vwc_req_if.sink                          req_chan,
   vwc_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [vwc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [vwc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [vwc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   // Position counters only need to reach MAX_DIM - 1.
   localparam int POS_W   = $clog2(MAX_DIM);
   localparam int ENTRY_W = vwc_pkg::VALUE_W + 3 * POS_W + $bits(vwc_pkg::tag_type);

   vwc_pkg::dims_type  dims_ff;
   logic [1:0]         reg_index;
   logic               csr_write;

   logic               push_valid, push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;
   logic               start_valid, start_ready;
   vwc_pkg::sums_type  start_sums;

   // ------------------------------------------------------------------------
   // Configuration registers. The APB port never waits, so a write lands at
   // the access cycle. Addresses past the last register are ignored on write
   // and read back as zero.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.width  <= vwc_pkg::DIM_RESET;
         dims_ff.height <= vwc_pkg::DIM_RESET;
         dims_ff.depth  <= vwc_pkg::DIM_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            vwc_pkg::REG_VOL_WIDTH:  dims_ff.width  <= csr_pwdata[vwc_pkg::CFG_W-1:0];
            vwc_pkg::REG_VOL_HEIGHT: dims_ff.height <= csr_pwdata[vwc_pkg::CFG_W-1:0];
            vwc_pkg::REG_VOL_DEPTH:  dims_ff.depth  <= csr_pwdata[vwc_pkg::CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         vwc_pkg::REG_VOL_WIDTH:  csr_prdata = vwc_pkg::CSR_DATA_W'(dims_ff.width);
         vwc_pkg::REG_VOL_HEIGHT: csr_prdata = vwc_pkg::CSR_DATA_W'(dims_ff.height);
         vwc_pkg::REG_VOL_DEPTH:  csr_prdata = vwc_pkg::CSR_DATA_W'(dims_ff.depth);
         default:                 csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Front end: raster position tracking and interior / last tagging.
   // ------------------------------------------------------------------------
   vwc_front #(
      .MAX_DIM (MAX_DIM),
      .POS_W   (POS_W),
      .ENTRY_W (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .dims       (dims_ff),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   // ------------------------------------------------------------------------
   // Queue between the tagged voxels and the accumulator.
   // ------------------------------------------------------------------------
   vwc_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // ------------------------------------------------------------------------
   // Back end: moment and mass accumulation, then the divider, which also
   // serves as the output register of the response channel.
   // ------------------------------------------------------------------------
   vwc_accum #(
      .POS_W   (POS_W),
      .ENTRY_W (ENTRY_W)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_data    (pop_data),
      .pop_ready   (pop_ready),
      .start_valid (start_valid),
      .start_sums  (start_sums),
      .start_ready (start_ready)
   );

   vwc_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start_valid (start_valid),
      .start_sums  (start_sums),
      .start_ready (start_ready),
      .rsp_chan    (rsp_chan)
   );

endmodule

// ===== design/vwc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume weighted centroid front end
// Tracks the raster position of each voxel beat and tags it as interior
// and as the last voxel of the volume before pushing it into the queue.
// ----------------------------------------------------------------------------
module vwc_front #(
   parameter int MAX_DIM = 1024,
   parameter int POS_W   = $clog2(MAX_DIM),
   parameter int ENTRY_W = vwc_pkg::VALUE_W + 3 * POS_W + $bits(vwc_pkg::tag_type)
) (
   input  logic               clock,
   input  logic               reset,
   input  vwc_pkg::dims_type  dims,
   vwc_req_if.sink            req_chan,
   output logic               push_valid,
   output logic [ENTRY_W-1:0] push_data,
   input  logic               push_ready
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CMP_W = (DIM_W > vwc_pkg::CFG_W) ? DIM_W : vwc_pkg::CFG_W;

   logic [POS_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [POS_W-1:0] pos_x_in, pos_y_in, pos_z_in;
   logic [CMP_W-1:0] dim_w, dim_h, dim_d;
   logic             end_x, end_y, end_z;
   logic             accept;
   vwc_pkg::tag_type tag;

   // Dimensions are clamped to 1..MAX_DIM before use.
   function automatic logic [CMP_W-1:0] clamp_dim(input logic [vwc_pkg::CFG_W-1:0] v);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(v);
      if (ext == '0) begin
         return CMP_W'(1);
      end
      if (ext > CMP_W'(MAX_DIM)) begin
         return CMP_W'(MAX_DIM);
      end
      return ext;
   endfunction

   function automatic logic is_interior(input logic [POS_W-1:0] p,
                                        input logic [CMP_W-1:0] n);
      logic [CMP_W-1:0] pe;
      pe = CMP_W'(p);
      return (pe != '0) && (n >= CMP_W'(3)) && (pe <= n - CMP_W'(2));
   endfunction

   assign dim_w = clamp_dim(dims.width);
   assign dim_h = clamp_dim(dims.height);
   assign dim_d = clamp_dim(dims.depth);

   assign end_x = CMP_W'(pos_x_ff) >= dim_w - CMP_W'(1);
   assign end_y = CMP_W'(pos_y_ff) >= dim_h - CMP_W'(1);
   assign end_z = CMP_W'(pos_z_ff) >= dim_d - CMP_W'(1);

   assign tag.interior = is_interior(pos_x_ff, dim_w) && is_interior(pos_y_ff, dim_h) &&
                         is_interior(pos_z_ff, dim_d);
   assign tag.last     = end_x && end_y && end_z;

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;
   assign push_data      = {req_chan.voxel_value, pos_x_ff, pos_y_ff, pos_z_ff, tag};
   assign accept         = req_chan.valid && push_ready;

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (tag.last) begin
         pos_x_in = '0;
         pos_y_in = '0;
         pos_z_in = '0;
      end else if (!end_x) begin
         pos_x_in = pos_x_ff + POS_W'(1);
      end else begin
         pos_x_in = '0;
         if (!end_y) begin
            pos_y_in = pos_y_ff + POS_W'(1);
         end else begin
            pos_y_in = '0;
            pos_z_in = pos_z_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else if (accept) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
      end
   end

endmodule

// ===== design/vwc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume weighted centroid queue
// Small register FIFO that decouples the position tracker from the
// accumulator so that each side can stall on its own.
// ----------------------------------------------------------------------------
module vwc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop_ready
);

   localparam int PTR_W = $clog2(vwc_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(vwc_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [vwc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(vwc_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(vwc_pkg::QUEUE_DEPTH - 1)) ? '0 :
                         wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(vwc_pkg::QUEUE_DEPTH - 1)) ? '0 :
                         rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

// ===== design/vwc_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume weighted centroid accumulator
// Adds value times position and the value itself for interior voxels, and
// hands the finished sums to the divider at the last voxel of a volume.
// ----------------------------------------------------------------------------
module vwc_accum #(
   parameter int POS_W   = 10,
   parameter int ENTRY_W = vwc_pkg::VALUE_W + 3 * POS_W + $bits(vwc_pkg::tag_type)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  logic [ENTRY_W-1:0] pop_data,
   output logic               pop_ready,
   output logic               start_valid,
   output vwc_pkg::sums_type  start_sums,
   input  logic               start_ready
);

   localparam int PROD_W = vwc_pkg::VALUE_W + POS_W;

   logic [vwc_pkg::VALUE_W-1:0] value;
   logic [POS_W-1:0]            pos_x, pos_y, pos_z;
   vwc_pkg::tag_type            tag;
   logic [PROD_W-1:0]           prod_x, prod_y, prod_z;
   vwc_pkg::sums_type           sums_ff, sums_in;
   logic                        fire;

   assign {value, pos_x, pos_y, pos_z, tag} = pop_data;

   assign prod_x = PROD_W'(value) * PROD_W'(pos_x);
   assign prod_y = PROD_W'(value) * PROD_W'(pos_y);
   assign prod_z = PROD_W'(value) * PROD_W'(pos_z);

   always_comb begin
      sums_in = sums_ff;
      if (tag.interior) begin
         sums_in.moment_x = sums_ff.moment_x + vwc_pkg::MOMENT_W'(prod_x);
         sums_in.moment_y = sums_ff.moment_y + vwc_pkg::MOMENT_W'(prod_y);
         sums_in.moment_z = sums_ff.moment_z + vwc_pkg::MOMENT_W'(prod_z);
         sums_in.mass     = sums_ff.mass + vwc_pkg::MASS_W'(value);
      end
   end

   // A last voxel waits here until the divider can take the sums.
   assign pop_ready   = !tag.last || start_ready;
   assign start_valid = pop_valid && tag.last;
   assign start_sums  = sums_in;
   assign fire        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff <= '0;
      end else if (fire) begin
         sums_ff <= tag.last ? '0 : sums_in;
      end
   end

endmodule

// ===== design/vwc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume weighted centroid divider
// Restoring divider, one quotient bit per cycle, shared by the three axes.
// It also holds the finished result until the response beat is taken.
// ----------------------------------------------------------------------------
module vwc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start_valid,
   input  vwc_pkg::sums_type start_sums,
   output logic              start_ready,
   vwc_rsp_if.source         rsp_chan
);

   vwc_pkg::div_state_type              state_ff, state_in;
   vwc_pkg::axis_type                   axis_ff;
   logic [vwc_pkg::STEP_W-1:0]          step_ff;
   vwc_pkg::sums_type                   sums_ff;
   logic [vwc_pkg::NUM_W-1:0]           num_ff;
   logic [vwc_pkg::MASS_W-1:0]          rem_ff, rem_in;
   logic [vwc_pkg::COORD_W-1:0]         quo_ff, quo_in;
   logic [vwc_pkg::COORD_W-1:0]         cx_ff, cy_ff, cz_ff;
   logic                                empty_ff;
   logic [vwc_pkg::MASS_W:0]            trial, diff;
   logic                                fits;

   assign trial  = {rem_ff, num_ff[vwc_pkg::NUM_W-1]};
   assign diff   = trial - {1'b0, sums_ff.mass};
   assign fits   = trial >= {1'b0, sums_ff.mass};
   assign rem_in = fits ? diff[vwc_pkg::MASS_W-1:0] : trial[vwc_pkg::MASS_W-1:0];
   assign quo_in = {quo_ff[vwc_pkg::COORD_W-2:0], fits};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vwc_pkg::DIV_IDLE: begin
            if (start_valid) begin
               state_in = (start_sums.mass == '0) ? vwc_pkg::DIV_DONE : vwc_pkg::DIV_RUN;
            end
         end
         vwc_pkg::DIV_RUN: begin
            if (step_ff == vwc_pkg::STEP_LAST && axis_ff == vwc_pkg::AXIS_Z) begin
               state_in = vwc_pkg::DIV_DONE;
            end
         end
         vwc_pkg::DIV_DONE: begin
            if (rsp_chan.ready) begin
               state_in = vwc_pkg::DIV_IDLE;
            end
         end
         default: state_in = vwc_pkg::DIV_IDLE;
      endcase
   end

   always_comb begin
      start_ready           = state_ff == vwc_pkg::DIV_IDLE;
      rsp_chan.valid        = state_ff == vwc_pkg::DIV_DONE;
      rsp_chan.centroid_x   = cx_ff;
      rsp_chan.centroid_y   = cy_ff;
      rsp_chan.centroid_z   = cz_ff;
      rsp_chan.empty_volume = empty_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vwc_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         vwc_pkg::DIV_IDLE: begin
            if (start_valid) begin
               sums_ff  <= start_sums;
               num_ff   <= {start_sums.moment_x, vwc_pkg::FRAC_W'(0)};
               rem_ff   <= '0;
               quo_ff   <= '0;
               step_ff  <= '0;
               axis_ff  <= vwc_pkg::AXIS_X;
               cx_ff    <= '0;
               cy_ff    <= '0;
               cz_ff    <= '0;
               empty_ff <= start_sums.mass == '0;
            end
         end
         vwc_pkg::DIV_RUN: begin
            if (step_ff == vwc_pkg::STEP_LAST) begin
               rem_ff  <= '0;
               quo_ff  <= '0;
               step_ff <= '0;
               unique case (axis_ff)
                  vwc_pkg::AXIS_X: begin
                     cx_ff   <= quo_in;
                     axis_ff <= vwc_pkg::AXIS_Y;
                     num_ff  <= {sums_ff.moment_y, vwc_pkg::FRAC_W'(0)};
                  end
                  vwc_pkg::AXIS_Y: begin
                     cy_ff   <= quo_in;
                     axis_ff <= vwc_pkg::AXIS_Z;
                     num_ff  <= {sums_ff.moment_z, vwc_pkg::FRAC_W'(0)};
                  end
                  default: begin
                     cz_ff <= quo_in;
                  end
               endcase
            end else begin
               num_ff  <= {num_ff[vwc_pkg::NUM_W-2:0], 1'b0};
               rem_ff  <= rem_in;
               quo_ff  <= quo_in;
               step_ff <= step_ff + vwc_pkg::STEP_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== tb/volume_weighted_centroid_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume weighted centroid testbench
// Streams whole and broken volumes of voxel beats through the block under a
// range of programmed dimensions and checks every centroid beat. Each result is
// checked against an in-bench model of the position counters, moment sums
// and fixed-point division.
// ----------------------------------------------------------------------------
module volume_weighted_centroid_tb;
   import vwc_pkg::*;

   localparam int          MAX_DIM      = 1024;
   localparam int          CLOCK_PERIOD = 10;
   localparam int          RESET_CYCLES = 7;
   // Settling time after the last voxel beat, meant to cover one result still
   // in flight in the divider.
   localparam int          DRAIN_CYCLES = 200;
   localparam int          LONG_STALL   = 2000;
   localparam int          RANDOM_ITEMS = 750;
   localparam int          RESULT_GOAL  = 10;
   localparam int          PRESSURE_LEN = 40;
   // Voxels sent along an oversized axis before the shape changes.
   localparam int          COLUMN_ITEMS = 180;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               empty;
   } centroid_type;

   typedef enum int {
      FILL_RANDOM,
      FILL_SPARSE,
      FILL_ZERO,
      FILL_EXTREME
   } fill_mode_type;

   logic clock;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   vwc_req_if req_chan ();
   vwc_rsp_if rsp_chan ();

   volume_weighted_centroid #(
      .MAX_DIM(MAX_DIM)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Dimensions as last written to the block, raw 11-bit register values.
   logic [CFG_W-1:0] cfg_width  = DIM_RESET;
   logic [CFG_W-1:0] cfg_height = DIM_RESET;
   logic [CFG_W-1:0] cfg_depth  = DIM_RESET;

   // Mirror of the accumulator: raster position and interior moment sums.
   logic [CFG_W-1:0]    col_x;
   logic [CFG_W-1:0]    row_y;
   logic [CFG_W-1:0]    slice_z;
   logic [MOMENT_W-1:0] sum_vx;
   logic [MOMENT_W-1:0] sum_vy;
   logic [MOMENT_W-1:0] sum_vz;
   logic [MASS_W-1:0]   sum_v;

   logic [VALUE_W-1:0] pending_voxels[$];
   centroid_type       expected_centroids[$];

   int unsigned results_predicted = 0;
   int unsigned error_count       = 0;

   // Idling controls, set by the stimulus process between phases.
   bit req_gaps_on  = 1'b1;
   bit rsp_gaps_on  = 1'b1;
   // Each flip asks the receiver for one long hold-off.
   bit stall_toggle = 1'b0;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Dimensions below one are taken as one and above MAX_DIM as MAX_DIM.
   function automatic logic [CFG_W-1:0] effective_dim(input logic [CFG_W-1:0] raw);
      if (raw == '0) return CFG_W'(1);
      if (raw > CFG_W'(MAX_DIM)) return CFG_W'(MAX_DIM);
      return raw;
   endfunction

   // A position counts only when it is off the border on its axis.
   function automatic bit in_core(input logic [CFG_W-1:0] p, input logic [CFG_W-1:0] n);
      return (p >= 1) && (n >= 3) && (p <= n - 2);
   endfunction

   function automatic logic [COORD_W-1:0] fixed_mean(input logic [MOMENT_W-1:0] moment,
                                                     input logic [MASS_W-1:0] mass);
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] quot;
      num  = {moment, {FRAC_W{1'b0}}};
      quot = num / NUM_W'(mass);
      return quot[COORD_W-1:0];
   endfunction

   // Takes one voxel into the model. Returns 1 and fills the centroid when
   // this voxel closes the volume.
   function automatic bit accumulate_voxel(input logic [VALUE_W-1:0] v,
                                           output centroid_type res);
      logic [CFG_W-1:0] w;
      logic [CFG_W-1:0] h;
      logic [CFG_W-1:0] d;
      bit               end_x;
      bit               end_y;
      bit               end_z;
      w     = effective_dim(cfg_width);
      h     = effective_dim(cfg_height);
      d     = effective_dim(cfg_depth);
      // Counters left beyond the last index by a smaller setting count as
      // at the end, so they wrap on their next advance.
      end_x = col_x >= w - 1;
      end_y = row_y >= h - 1;
      end_z = slice_z >= d - 1;
      res   = '0;
      if (v != '0 && in_core(col_x, w) && in_core(row_y, h) && in_core(slice_z, d)) begin
         sum_vx = sum_vx + MOMENT_W'(v) * MOMENT_W'(col_x);
         sum_vy = sum_vy + MOMENT_W'(v) * MOMENT_W'(row_y);
         sum_vz = sum_vz + MOMENT_W'(v) * MOMENT_W'(slice_z);
         sum_v  = sum_v + MASS_W'(v);
      end
      if (end_x && end_y && end_z) begin
         if (sum_v == '0) begin
            res.empty = 1'b1;
         end else begin
            res.x = fixed_mean(sum_vx, sum_v);
            res.y = fixed_mean(sum_vy, sum_v);
            res.z = fixed_mean(sum_vz, sum_v);
         end
         col_x   = '0;
         row_y   = '0;
         slice_z = '0;
         sum_vx  = '0;
         sum_vy  = '0;
         sum_vz  = '0;
         sum_v   = '0;
         return 1'b1;
      end
      if (!end_x) begin
         col_x = col_x + 1;
      end else begin
         col_x = '0;
         if (!end_y) begin
            row_y = row_y + 1;
         end else begin
            row_y   = '0;
            slice_z = slice_z + 1;
         end
      end
      return 1'b0;
   endfunction

   // Mostly back-to-back, with some short gaps and the odd long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(30, 100);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value(input fill_mode_type mode);
      case (mode)
         FILL_SPARSE: begin
            if ($urandom_range(0, 7) == 0) return VALUE_W'($urandom_range(1, 255));
            return '0;
         end
         FILL_ZERO: begin
            return '0;
         end
         FILL_EXTREME: begin
            case ($urandom_range(0, 3))
               0: return VALUE_W'(0);
               1: return VALUE_W'(1);
               2: return VALUE_W'(254);
               default: return VALUE_W'(255);
            endcase
         end
         default: begin
            return VALUE_W'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // Small sizes dominate so that volumes close often; a zero value comes
   // through the clamp.
   function automatic logic [CFG_W-1:0] pick_dim();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 16) return CFG_W'(1);
      if (r < 24) return CFG_W'(2);
      return CFG_W'($urandom_range(3, 6));
   endfunction

   function automatic int unsigned volume_size();
      return effective_dim(cfg_width) * effective_dim(cfg_height) *
             effective_dim(cfg_depth);
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // One APB write: a setup phase, then an access phase held until pready.
   task automatic csr_write(input logic [1:0] reg_index, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (reg_index)
         REG_VOL_WIDTH:  cfg_width  = value;
         REG_VOL_HEIGHT: cfg_height = value;
         default:        cfg_depth  = value;
      endcase
   endtask

   task automatic write_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic [CFG_W-1:0] d);
      csr_write(REG_VOL_WIDTH, w);
      csr_write(REG_VOL_HEIGHT, h);
      csr_write(REG_VOL_DEPTH, d);
   endtask

   // Appends one voxel to the driver's backlog.
   task automatic add_voxel(input logic [VALUE_W-1:0] v);
      pending_voxels = {pending_voxels, v};
   endtask

   task automatic push_voxels(input int unsigned count, input fill_mode_type mode);
      @(negedge clock);
      for (int unsigned i = 0; i < count; i++) begin
         add_voxel(pick_value(mode));
      end
   endtask

   // Waits until every queued voxel has been taken and every expected
   // centroid has come back, then lets the divider settle so that a
   // register write never lands on a busy block.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_voxels.size() != 0 || req_chan.valid || expected_centroids.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Voxel driver. A beat is predicted on the edge that accepts it; a new
   // beat is offered only once the previous one is gone, after its gap.
   int unsigned req_gap_left;
   always @(posedge clock) begin
      centroid_type res;
      if (reset) begin
         req_chan.valid       <= 1'b0;
         req_chan.voxel_value <= '0;
         req_gap_left = 0;
         col_x   = '0;
         row_y   = '0;
         slice_z = '0;
         sum_vx  = '0;
         sum_vy  = '0;
         sum_vz  = '0;
         sum_v   = '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (accumulate_voxel(req_chan.voxel_value, res)) begin
               expected_centroids = {expected_centroids, res};
               results_predicted++;
            end
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_voxels.size() > 0) begin
               req_chan.voxel_value <= pending_voxels.pop_front();
               req_chan.valid       <= 1'b1;
               req_gap_left = req_gaps_on ? pick_gap() : 0;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver. Random hold-offs, plus one long hold-off whenever the
   // stimulus flips the stall request.
   int unsigned rsp_hold_left;
   bit          stall_seen;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold_left = 0;
         stall_seen    = stall_toggle;
      end else if (stall_toggle != stall_seen) begin
         stall_seen    = stall_toggle;
         rsp_hold_left = LONG_STALL;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         rsp_hold_left = rsp_gaps_on ? pick_gap() : 0;
      end
   end

   // Result monitor: every accepted centroid beat is checked against the
   // oldest expected one, field by field.
   always @(posedge clock) begin
      centroid_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_centroids.size() == 0) begin
            report_mismatch("result beats pending", 1, 0);
         end else begin
            want = expected_centroids.pop_front();
            if (rsp_chan.centroid_x !== want.x)
               report_mismatch("centroid_x", rsp_chan.centroid_x, want.x);
            if (rsp_chan.centroid_y !== want.y)
               report_mismatch("centroid_y", rsp_chan.centroid_y, want.y);
            if (rsp_chan.centroid_z !== want.z)
               report_mismatch("centroid_z", rsp_chan.centroid_z, want.z);
            if (rsp_chan.empty_volume !== want.empty)
               report_mismatch("empty_volume", rsp_chan.empty_volume, want.empty);
         end
      end
   end

   // Main sequence: directed volumes, an oversized column, a back-pressure
   // phase, then random phases of whole and broken volumes.
   initial begin
      int unsigned random_items;
      int unsigned results_base;
      int unsigned n;
      int unsigned count;
      int unsigned volumes;
      bit          long_line;
      logic [CFG_W-1:0] w;
      logic [CFG_W-1:0] h;
      logic [CFG_W-1:0] d;

      reset                = 1'b1;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      req_chan.valid       = 1'b0;
      req_chan.voxel_value = '0;
      rsp_chan.ready       = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // A width of zero is clamped to one, so every voxel is a volume of its
      // own with no interior and each result is empty.
      write_dims('0, CFG_W'(1), CFG_W'(1));
      @(negedge clock);
      add_voxel(VALUE_W'(0));
      add_voxel(VALUE_W'(255));
      add_voxel(VALUE_W'(1));
      add_voxel(VALUE_W'(128));
      wait_idle();

      // The smallest volume with an interior: a single bright center voxel
      // puts every centroid exactly at index one.
      write_dims(CFG_W'(3), CFG_W'(3), CFG_W'(3));
      @(negedge clock);
      for (int i = 0; i < 27; i++) begin
         add_voxel(i == 13 ? VALUE_W'(255) : VALUE_W'(0));
      end
      wait_idle();

      // A deep column streamed without gaps: the oversized depth is clamped
      // to MAX_DIM and only its first slices are sent, so the interior sums
      // carry over and the next, smaller shape closes the volume at once.
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      write_dims(CFG_W'(3), CFG_W'(3), CFG_W'(2047));
      push_voxels(COLUMN_ITEMS, FILL_EXTREME);
      wait_idle();

      // Back-pressure: one-voxel volumes keep coming while the receiver
      // holds off, so the voxel queue fills and the block stalls its input.
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      write_dims(CFG_W'(1), CFG_W'(1), CFG_W'(1));
      @(negedge clock);
      stall_toggle = ~stall_toggle;
      push_voxels(PRESSURE_LEN, FILL_RANDOM);
      wait_idle();

      // Random phases. A phase may end partway through a volume, so the next
      // phase's register writes land mid-volume.
      random_items = 0;
      results_base = results_predicted;
      while (random_items < RANDOM_ITEMS || results_predicted - results_base < RESULT_GOAL) begin
         req_gaps_on = ($urandom_range(0, 4) != 0);
         rsp_gaps_on = ($urandom_range(0, 4) != 0);
         long_line   = ($urandom_range(0, 19) == 0);
         if (long_line) begin
            // A long line along one axis, clamped from an oversized value.
            w = CFG_W'($urandom_range(0, 2));
            h = CFG_W'($urandom_range(0, 2));
            d = CFG_W'($urandom_range(0, 2));
            case ($urandom_range(0, 2))
               0: w = CFG_W'($urandom_range(MAX_DIM, 2047));
               1: h = CFG_W'($urandom_range(MAX_DIM, 2047));
               default: d = CFG_W'($urandom_range(MAX_DIM, 2047));
            endcase
         end else begin
            w = pick_dim();
            h = pick_dim();
            d = pick_dim();
         end
         write_dims(w, h, d);
         n       = volume_size();
         volumes = long_line ? 1 : $urandom_range(1, 3);
         for (int unsigned v = 0; v < volumes; v++) begin
            count = n;
            if (long_line) begin
               // Only a stretch of the line; a later shape wraps it up.
               count = $urandom_range(1, COLUMN_ITEMS);
            end else if (v == volumes - 1 && $urandom_range(0, 5) == 0) begin
               count = $urandom_range(1, n);
            end
            push_voxels(count, fill_mode_type'($urandom_range(0, 3)));
            random_items += count;
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Run limit for the sequence above.
   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== volume_weighted_centroid.f =====
design/vwc_pkg.sv
design/vwc_req_if.sv
design/vwc_rsp_if.sv
design/vwc_front.sv
design/vwc_queue.sv
design/vwc_accum.sv
design/vwc_div.sv
design/volume_weighted_centroid.sv
tb/volume_weighted_centroid_tb.sv
